/* rtl/clsrng_pkg.sv */
`default_nettype none

package clsrng_pkg;

    // default shuffle table depth
    localparam int TABLE_DEPTH_DEF = 32;

    // extra warm-up steps in front of the table fill
    localparam int WARMUP = 8;

    // generator constants
    localparam logic [31:0] MOD_ONE = 32'd2147483563;
    localparam logic [31:0] MOD_TWO = 32'd2147483399;
    localparam logic [15:0] MUL_ONE = 16'd40014;
    localparam logic [15:0] MUL_TWO = 16'd40692;

    // 2^31 mod modulus, used to fold the top bits of a product back in
    localparam logic [7:0] FOLD_ONE = 8'd85;
    localparam logic [7:0] FOLD_TWO = 8'd249;

    // largest output value and generator two reset value
    localparam logic [30:0] TOP_VALUE     = 31'd2147483562;
    localparam logic [30:0] GEN_TWO_RESET = 31'd123456789;

    // product width of a 31-bit state times a 16-bit multiplier
    localparam int PROD_W = 47;

    // reduce a 47-bit product modulo m, with c = 2^31 mod m
    // the folded sum stays below 2*m, so one subtract finishes it
    function automatic logic [30:0] mod_fold(
        input logic [PROD_W-1:0] p,
        input logic [7:0]        c,
        input logic [31:0]       m
    );
        logic [31:0] s;
        s = ({16'd0, p[46:31]} * {24'd0, c}) + {1'b0, p[30:0]};
        if (s >= m)
        begin
            s = s - m;
        end
        return s[30:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/combined_lcg_shuffle_rng_core.sv */
`default_nettype none

// channel | signals                          | direction | beat content
// --------+----------------------------------+-----------+------------------------------
// in      | in_valid, in_ready, mode, seed   | into core | draw, or reseed then draw
// out     | out_valid, out_ready, value      | out of core | one shuffled value per input
//
// a draw steps from the accept cycle through product, fold plus table read, and table
// write plus output subtract, the last step loading the output register.
// a reseed first runs TABLE_DEPTH+8 warm-up steps, each a product and a fold, through
// the generator one multiplier.
// reset loads the generator start values and clears the table valid bits; no clearing pass.
// the next beat is taken while a result waits; only the final step stalls on out_ready.
module combined_lcg_shuffle_rng_core #(
    parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [30:0] seed,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [30:0] value
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int WARM     = TABLE_DEPTH + clsrng_pkg::WARMUP;
    localparam int CNT_W    = $clog2(WARM);
    localparam int SLOT_DIV = 1 + int'(clsrng_pkg::TOP_VALUE) / TABLE_DEPTH;
    localparam int PW       = clsrng_pkg::PROD_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WMUL = 6'b000010,
        ST_WRED = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_RED  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [30:0]            g1_reg, g1_next;
    logic [30:0]            g2_reg, g2_next;
    logic [30:0]            last_reg, last_next;
    logic [PW-1:0]          p1_reg, p2_reg;
    logic [TABLE_DEPTH-2:0] therm_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [30:0]            value_reg, value_next;

    logic                   accept;
    logic                   load_draw;
    logic                   load_warm;
    logic [30:0]            seed_clamped;
    logic [30:0]            g1_fold;
    logic [30:0]            g2_fold;
    logic [IDX_W-1:0]       slot;
    logic [CNT_W-1:0]       fill_idx;
    logic                   out_free;
    logic [32:0]            diff;
    logic [32:0]            diff_wrap;

    logic                   tbl_rd_en;
    logic [30:0]            tbl_rd_data;
    logic                   tbl_wr_en;
    logic [IDX_W-1:0]       tbl_wr_addr;
    logic [30:0]            tbl_wr_data;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // products are taken on a draw accept, after warm-up, or per warm-up step
    assign load_draw = (accept && mode) || (state_reg == ST_MUL);
    assign load_warm = (state_reg == ST_WMUL);

    // seed clamp: zero becomes one, anything past the top value saturates
    always_comb
    begin
        seed_clamped = seed;
        if (seed == 31'd0)
        begin
            seed_clamped = 31'd1;
        end
        else if (seed > clsrng_pkg::TOP_VALUE)
        begin
            seed_clamped = clsrng_pkg::TOP_VALUE;
        end
    end

    // multiplier stage
    always_ff @(posedge clk)
    begin
        if (load_draw || load_warm)
        begin
            p1_reg <= PW'(g1_reg) * PW'(clsrng_pkg::MUL_ONE);
        end
        if (load_draw)
        begin
            p2_reg <= PW'(g2_reg) * PW'(clsrng_pkg::MUL_TWO);
        end
    end

    // slot thresholds: bit k says last output reached (k+1) slot widths
    for (genvar k = 1; k < TABLE_DEPTH; k++)
    begin : g_therm
        localparam logic [30:0] THR = 31'(k * SLOT_DIV);
        always_ff @(posedge clk)
        begin
            if (load_draw)
            begin
                therm_reg[k-1] <= (last_reg >= THR);
            end
        end
    end

    // slot index is the height of the threshold thermometer
    always_comb
    begin
        slot = '0;
        for (int k = 0; k < TABLE_DEPTH - 1; k++)
        begin
            if (therm_reg[k])
            begin
                slot = IDX_W'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RED)
        begin
            slot_reg <= slot;
        end
    end

    // modular fold of both products
    assign g1_fold = clsrng_pkg::mod_fold(p1_reg, clsrng_pkg::FOLD_ONE, clsrng_pkg::MOD_ONE);
    assign g2_fold = clsrng_pkg::mod_fold(p2_reg, clsrng_pkg::FOLD_TWO, clsrng_pkg::MOD_TWO);

    // table fill goes deepest slot first during warm-up
    assign fill_idx = CNT_W'(WARM - 1) - cnt_reg;

    // old slot contents minus generator two, wrapped into range
    always_comb
    begin
        diff      = {2'b00, tbl_rd_data} - {2'b00, g2_reg};
        diff_wrap = diff;
        if (diff[32] || (diff == 33'd0))
        begin
            diff_wrap = diff + {2'b00, clsrng_pkg::TOP_VALUE};
        end
    end

    // table access: read in the fold cycle, write back in the output cycle
    // the write always lands before the next draw's read, so no forwarding
    assign tbl_rd_en = (state_reg == ST_RED);

    // warm-up stores the freshly stepped generator one value
    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = slot_reg;
        tbl_wr_data = g1_reg;
        if (state_reg == ST_WRED)
        begin
            tbl_wr_en   = (cnt_reg >= CNT_W'(clsrng_pkg::WARMUP));
            tbl_wr_addr = fill_idx[IDX_W-1:0];
            tbl_wr_data = g1_fold;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            tbl_wr_en = 1'b1;
        end
    end

    clsrng_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd_en),
        .rd_addr (slot),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        state_next = ST_RED;
                    end
                    else
                    begin
                        g1_next    = seed_clamped;
                        g2_next    = seed_clamped;
                        cnt_next   = '0;
                        state_next = ST_WMUL;
                    end
                end
            end
            ST_WMUL:
            begin
                state_next = ST_WRED;
            end
            ST_WRED:
            begin
                g1_next  = g1_fold;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WARM - 1))
                begin
                    last_next  = g1_fold;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_WMUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                g1_next    = g1_fold;
                g2_next    = g2_fold;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    last_next      = diff_wrap[30:0];
                    value_next     = diff_wrap[30:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g1_reg        <= 31'd1;
            g2_reg        <= clsrng_pkg::GEN_TWO_RESET;
            last_reg      <= 31'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

`default_nettype wire

/* rtl/clsrng_table.sv */
`default_nettype none

module clsrng_table #(
    parameter int TABLE_DEPTH = clsrng_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [30:0]      rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [30:0]      wr_data
);

    logic [30:0]            mem [TABLE_DEPTH];
    logic [30:0]            rd_data_reg;
    logic                   rd_vld_reg;
    logic [TABLE_DEPTH-1:0] vld_reg;

    // storage array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry valid bits, an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 31'd0;

endmodule

`default_nettype wire

/* rtl/clsrng_checker.sv */
`default_nettype none

module clsrng_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        mode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [30:0] value
);

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("output beat changed while stalled");

    // every result lies in 1..top value
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value != 31'd0) && (value <= clsrng_pkg::TOP_VALUE))
        else $error("output value out of range");

    // one item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a reseed is still warming up several cycles later
    a_reseed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode |-> ##4 !in_ready)
        else $error("reseed finished too early");

endmodule

bind combined_lcg_shuffle_rng_core clsrng_checker u_clsrng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
);

`default_nettype wire

/* tb/sv/tb_combined_lcg_shuffle_rng_core.sv */
`timescale 1ns / 100ps

// input beat kinds
localparam logic MODE_RESEED = 1'b0;
localparam logic MODE_DRAW   = 1'b1;

localparam int SHUF_DEPTH = clsrng_pkg::TABLE_DEPTH_DEF;

// shadow generator and queue of values still owed by the core
class rng_scoreboard;
    logic [30:0] gen_one;
    logic [30:0] gen_two;
    logic [30:0] prev_value;
    logic [30:0] shuffle_tab [SHUF_DEPTH];
    logic [30:0] owed_values [$];
    int          mismatches;

    function new();
        gen_one    = 31'd1;
        gen_two    = clsrng_pkg::GEN_TWO_RESET;
        prev_value = 31'd0;
        foreach (shuffle_tab[i])
        begin
            shuffle_tab[i] = 31'd0;
        end
        mismatches = 0;
    endfunction

    // one congruential step, x * a mod m
    function automatic logic [30:0] lcg_step(logic [30:0] x, longint unsigned a,
                                             longint unsigned m);
        longint unsigned prod;
        prod = {33'd0, x} * a;
        return 31'(prod % m);
    endfunction

    // advance both generators and pull one value through the shuffle table
    function automatic logic [30:0] next_draw();
        longint unsigned slot_div;
        longint unsigned slot;
        longint          diff;
        slot_div = longint'(clsrng_pkg::TOP_VALUE) / SHUF_DEPTH + 1;
        gen_one  = lcg_step(gen_one, clsrng_pkg::MUL_ONE, clsrng_pkg::MOD_ONE);
        gen_two  = lcg_step(gen_two, clsrng_pkg::MUL_TWO, clsrng_pkg::MOD_TWO);
        slot     = longint'(prev_value) / slot_div;
        if (slot >= SHUF_DEPTH)
        begin
            slot = SHUF_DEPTH - 1;
        end
        diff = longint'(shuffle_tab[slot]) - longint'(gen_two);
        shuffle_tab[slot] = gen_one;
        if (diff < 1)
        begin
            diff = diff + longint'(clsrng_pkg::TOP_VALUE);
        end
        prev_value = 31'(diff);
        return prev_value;
    endfunction

    // load the seed, run the warm-up and refill the table deepest slot first
    function automatic void reseed(logic [30:0] s);
        logic [30:0] start;
        start = s;
        if (start == 31'd0)
        begin
            start = 31'd1;
        end
        if (start > clsrng_pkg::TOP_VALUE)
        begin
            start = clsrng_pkg::TOP_VALUE;
        end
        gen_one = start;
        gen_two = start;
        for (int j = SHUF_DEPTH + clsrng_pkg::WARMUP - 1; j >= 0; j--)
        begin
            gen_one = lcg_step(gen_one, clsrng_pkg::MUL_ONE, clsrng_pkg::MOD_ONE);
            if (j < SHUF_DEPTH)
            begin
                shuffle_tab[j] = gen_one;
            end
        end
        prev_value = shuffle_tab[0];
    endfunction

    // accepted input beat
    function void note_input(logic m, logic [30:0] s);
        if (m == MODE_RESEED)
        begin
            reseed(s);
        end
        owed_values.push_back(next_draw());
    endfunction

    // accepted output beat
    function void check_value(logic [30:0] v);
        logic [30:0] want;
        if (owed_values.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("value %0d arrived with nothing pending", v);
            end
            return;
        end
        want = owed_values.pop_front();
        if (v !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("value mismatch: expected %0d, got %0d", want, v);
            end
        end
    endfunction

    function int pending();
        return owed_values.size();
    endfunction
endclass

module tb_combined_lcg_shuffle_rng_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS = 450;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [30:0] seed;
    logic        out_valid;
    logic        out_ready;
    logic [30:0] value;

    int send_idle_pct;
    int stall_pct;
    int cycles;

    rng_scoreboard sb = new();

    // seeds at and around the edges of the valid range
    logic [30:0] edge_seeds [8] = '{
        31'd0, 31'd1, 31'd2147483562, 31'd2147483563,
        31'h7FFFFFFF, 31'd2147483399, 31'd2147483398, 31'd123456789
    };

    combined_lcg_shuffle_rng_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .seed      (seed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // run limit
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("combined_lcg_shuffle_rng_core verification failed");
            $finish;
        end
    end

    // watch both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_input(mode, seed);
            end
            if (out_valid && out_ready)
            begin
                sb.check_value(value);
            end
        end
    end

    // receiver backpressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // present one input beat and hold it until taken
    task automatic send_beat(input logic m, input logic [30:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            mode     <= 1'($urandom());
            seed     <= 31'($urandom());
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        seed     <= s;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic [30:0] pick_seed();
        if ($urandom_range(9) == 0)
        begin
            return edge_seeds[$urandom_range(7)];
        end
        return 31'($urandom());
    endfunction

    initial
    begin
        logic m;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_DRAW;
        seed          = 31'd0;
        out_ready     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // reset held low, then released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // draws straight out of reset, seed field ignored
        send_beat(MODE_DRAW, 31'd0);
        send_beat(MODE_DRAW, 31'h7FFFFFFF);
        send_beat(MODE_DRAW, 31'h2AAAAAAA);
        // zero seed
        send_beat(MODE_RESEED, 31'd0);
        send_beat(MODE_DRAW, 31'h55555555);
        send_beat(MODE_RESEED, 31'd1);
        send_beat(MODE_DRAW, 31'd0);
        // largest legal seed, then seeds above it
        send_beat(MODE_RESEED, 31'd2147483562);
        send_beat(MODE_DRAW, 31'd0);
        send_beat(MODE_RESEED, 31'd2147483563);
        send_beat(MODE_RESEED, 31'h7FFFFFFF);
        send_beat(MODE_DRAW, 31'd0);
        // second generator locks at zero
        send_beat(MODE_RESEED, 31'd2147483399);
        for (int i = 0; i < 6; i++)
        begin
            send_beat(MODE_DRAW, 31'($urandom()));
        end
        send_beat(MODE_RESEED, 31'd2147483398);
        send_beat(MODE_DRAW, 31'd0);
        send_beat(MODE_RESEED, 31'd123456789);
        send_beat(MODE_DRAW, 31'd0);

        // random runs of draws broken by reseeds, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 47;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct     = 17;
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                m = ($urandom_range(99) < 8) ? MODE_RESEED : MODE_DRAW;
                send_beat(m, pick_seed());
            end
        end
        in_valid      <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // drain
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("combined_lcg_shuffle_rng_core verification clean");
        end
        else
        begin
            $display("combined_lcg_shuffle_rng_core verification failed");
        end
        $finish;
    end

endmodule

/* combined_lcg_shuffle_rng_core.f */
rtl/clsrng_pkg.sv
rtl/clsrng_table.sv
rtl/combined_lcg_shuffle_rng_core.sv
rtl/clsrng_checker.sv
tb/sv/tb_combined_lcg_shuffle_rng_core.sv
